FILE: hdl/urs_pkg.sv
// Shared types, constants and register codes for the ultrasonic range and speed meter.
`default_nettype none
package urs_pkg;

    // Default structural sizes
    localparam int TIME_WIDTH_DEF = 32;
    localparam int WIDTH_BITS_DEF = 16;

    // Fixed field widths
    localparam int DIST_W    = 11;
    localparam int SPEED_W   = 22;
    localparam int PROD_W    = 31;
    localparam int TICK_W    = 8;
    localparam int GAP_REG_W = 20;
    localparam int DIV_W     = 8;

    // Stream and register port sizes
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    // Job queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // Arithmetic constants
    localparam logic [PROD_W-1:0]  SPEED_SCALE   = PROD_W'(1000000);
    localparam logic [DIST_W-1:0]  DIST_MAX      = '1;
    localparam logic [SPEED_W-1:0] SPEED_MAX     = {1'b0, {(SPEED_W-1){1'b1}}};
    localparam logic [SPEED_W-1:0] SPEED_MIN     = {1'b1, {(SPEED_W-1){1'b0}}};
    localparam logic [PROD_W-1:0]  SPEED_POS_LIM = PROD_W'(2097151);
    localparam logic [PROD_W-1:0]  SPEED_NEG_LIM = PROD_W'(2097152);

    // Register reset values
    localparam logic [TICK_W-1:0]    TRIG_LOW_RST  = TICK_W'(2);
    localparam logic [TICK_W-1:0]    TRIG_HIGH_RST = TICK_W'(10);
    localparam logic [GAP_REG_W-1:0] MIN_GAP_RST   = GAP_REG_W'(1000);
    localparam logic [DIV_W-1:0]     WIDTH_DIV_RST = DIV_W'(58);

    // Register indexes (byte address divided by four)
    typedef enum logic [1:0] {
        REG_TRIG_LOW  = 2'd0,
        REG_TRIG_HIGH = 2'd1,
        REG_MIN_GAP   = 2'd2,
        REG_WIDTH_DIV = 2'd3
    } urs_reg_idx_t;

    // Trigger sequencer phases
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LOW,
        PH_HIGH
    } urs_trig_phase_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        B_IDLE,
        B_DIVW,
        B_MUL,
        B_DIVS,
        B_SPD,
        B_OUT
    } urs_back_state_t;

    // Per-tick job flags handed from front to back
    typedef struct packed {
        logic speed_ok;
        logic done;
        logic trig;
    } urs_job_flags_t;

    localparam int FLAGS_W = $bits(urs_job_flags_t);

endpackage
`default_nettype wire

FILE: hdl/urs_front.sv
// Front end: tick counter, trigger sequencer and echo edge classification.
`default_nettype none
module urs_front
    import urs_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF,
    parameter int WIDTH_BITS = WIDTH_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_accept,
    input  wire logic                   echo_level,
    input  wire logic                   start_request,
    input  wire logic [TICK_W-1:0]      trig_low_ticks,
    input  wire logic [TICK_W-1:0]      trig_high_ticks,
    input  wire logic [GAP_REG_W-1:0]   min_gap_ticks,
    output urs_job_flags_t              job_flags,
    output logic [WIDTH_BITS-1:0]       job_width,
    output logic [TIME_WIDTH-1:0]       job_gap
);

    localparam int EXT_W = (TIME_WIDTH > WIDTH_BITS) ? TIME_WIDTH : WIDTH_BITS;
    localparam int CMP_W = (TIME_WIDTH > GAP_REG_W) ? TIME_WIDTH : GAP_REG_W;

    logic [TIME_WIDTH-1:0] tick_count_reg;
    logic [TIME_WIDTH-1:0] echo_start_reg;
    logic [TIME_WIDTH-1:0] prev_edge_reg;
    logic                  echo_prev_reg;
    logic                  have_prev_reg;
    urs_trig_phase_t       phase_reg, phase_next;
    logic [TICK_W-1:0]     trig_cnt_reg, trig_cnt_next;

    logic                  rise, fall, valid_fall;
    logic [TIME_WIDTH-1:0] width_raw;
    logic [EXT_W-1:0]      width_ext;
    logic [TICK_W-1:0]     cnt_inc;
    logic [TICK_W-1:0]     cnt_base;
    urs_trig_phase_t       phase_eff;

    // Trigger sequencer next state; a start in idle makes this tick the first low tick.
    always_comb begin
        phase_eff     = phase_reg;
        cnt_base      = trig_cnt_reg;
        if (phase_reg == PH_IDLE && start_request) begin
            phase_eff = PH_LOW;
            cnt_base  = '0;
        end
        cnt_inc       = cnt_base + TICK_W'(1);
        phase_next    = phase_eff;
        trig_cnt_next = cnt_base;
        case (phase_eff)
            PH_LOW: begin
                trig_cnt_next = cnt_inc;
                if (cnt_inc >= trig_low_ticks) begin
                    phase_next    = PH_HIGH;
                    trig_cnt_next = '0;
                end
            end
            PH_HIGH: begin
                trig_cnt_next = cnt_inc;
                if (cnt_inc >= trig_high_ticks) begin
                    phase_next    = PH_IDLE;
                    trig_cnt_next = '0;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Trigger output, echo edge detection and pulse width with saturation.
    // The trigger is high only during the pulse phase.
    always_comb begin
        job_flags.trig = (phase_reg == PH_HIGH);
        rise      = echo_level && !echo_prev_reg;
        fall      = !echo_level && echo_prev_reg;
        width_raw = tick_count_reg - echo_start_reg;
        width_ext = EXT_W'(width_raw);
        if (width_ext > EXT_W'({WIDTH_BITS{1'b1}})) begin
            job_width = '1;
        end else begin
            job_width = width_ext[WIDTH_BITS-1:0];
        end
        valid_fall     = fall && (width_raw != '0);
        job_gap        = tick_count_reg - prev_edge_reg;
        job_flags.done = valid_fall;
        job_flags.speed_ok = valid_fall && have_prev_reg && (job_gap != '0) &&
                             (CMP_W'(job_gap) >= CMP_W'(min_gap_ticks));
    end

    // State update on every accepted tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg <= '0;
            echo_start_reg <= '0;
            prev_edge_reg  <= '0;
            echo_prev_reg  <= 1'b0;
            have_prev_reg  <= 1'b0;
            phase_reg      <= PH_IDLE;
            trig_cnt_reg   <= '0;
        end else if (in_accept) begin
            tick_count_reg <= tick_count_reg + TIME_WIDTH'(1);
            echo_prev_reg  <= echo_level;
            phase_reg      <= phase_next;
            trig_cnt_reg   <= trig_cnt_next;
            if (rise) begin
                echo_start_reg <= tick_count_reg;
            end
            if (valid_fall) begin
                prev_edge_reg <= tick_count_reg;
                have_prev_reg <= 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: hdl/urs_queue.sv
// Small job queue that decouples the front end from the arithmetic back end.
`default_nettype none
module urs_queue
    import urs_pkg::*;
#(
    parameter int DATA_W = FLAGS_W + WIDTH_BITS_DEF + TIME_WIDTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    input  wire logic              pop,
    output logic [DATA_W-1:0]      head_data,
    output logic                   full,
    output logic                   empty
);

    logic [DATA_W-1:0]  entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    // Status flags and the head entry.
    assign full      = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_data = entry_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + Q_CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - Q_CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

FILE: hdl/urs_back.sv
// Back end: serial distance and speed division, result state and output register.
`default_nettype none
module urs_back
    import urs_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF,
    parameter int WIDTH_BITS = WIDTH_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  q_empty,
    input  urs_job_flags_t             q_flags,
    input  wire logic [WIDTH_BITS-1:0] q_width,
    input  wire logic [TIME_WIDTH-1:0] q_gap,
    output logic                       q_pop,
    input  wire logic [DIV_W-1:0]      width_divisor,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // Fields from bit 0: trig_level, measure_done, distance_cm[10:0],
    // speed_cm_s[21:0], speed_updated, zero padding.
    output logic [OUT_TDATA_W-1:0]     m_tdata
);

    localparam int MAX_STEPS = (WIDTH_BITS > PROD_W) ? WIDTH_BITS : PROD_W;
    localparam int CNT_W     = $clog2(MAX_STEPS);

    urs_back_state_t         state_reg, state_next;
    urs_job_flags_t          flags_reg;
    logic [WIDTH_BITS-1:0]   wq_reg;
    logic [DIV_W-1:0]        wrem_reg;
    logic [TIME_WIDTH-1:0]   gap_reg;
    logic [TIME_WIDTH-1:0]   srem_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic                    neg_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [DIST_W-1:0]       distance_reg;
    logic [DIST_W-1:0]       prev_distance_reg;
    logic [SPEED_W-1:0]      speed_reg;
    logic                    out_valid_reg;
    logic [OUT_TDATA_W-1:0]  out_data_reg;

    logic                    load_out;
    logic [DIV_W-1:0]        div_eff;
    logic [DIV_W:0]          w_shift, w_diff;
    logic                    w_ge;
    logic [DIV_W-1:0]        w_rem_next;
    logic [DIST_W-1:0]       d_sat;
    logic                    d_neg;
    logic [DIST_W-1:0]       d_mag;
    logic [PROD_W-1:0]       prod_full;
    logic [TIME_WIDTH:0]     s_shift, s_diff;
    logic                    s_ge;
    logic [TIME_WIDTH-1:0]   s_rem_next;
    logic [SPEED_W-1:0]      speed_sat;

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    state_next = q_flags.done ? B_DIVW : B_OUT;
                end
            end
            B_DIVW: begin
                if (cnt_reg == '0) begin
                    state_next = B_MUL;
                end
            end
            B_MUL: begin
                state_next = flags_reg.speed_ok ? B_DIVS : B_OUT;
            end
            B_DIVS: begin
                if (cnt_reg == '0) begin
                    state_next = B_SPD;
                end
            end
            B_SPD: begin
                state_next = B_OUT;
            end
            B_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        q_pop    = (state_reg == B_IDLE) && !q_empty;
        load_out = (state_reg == B_OUT) && (!out_valid_reg || m_tready);
    end

    // Distance divider step: one quotient bit per cycle.
    always_comb begin
        div_eff    = (width_divisor == '0) ? DIV_W'(1) : width_divisor;
        w_shift    = {wrem_reg, wq_reg[WIDTH_BITS-1]};
        w_diff     = w_shift - {1'b0, div_eff};
        w_ge       = (w_shift >= {1'b0, div_eff});
        w_rem_next = w_ge ? w_diff[DIV_W-1:0] : w_shift[DIV_W-1:0];
    end

    // Distance saturation, change against the previous distance and scaling.
    always_comb begin
        d_sat     = (|wq_reg[WIDTH_BITS-1:DIST_W]) ? DIST_MAX : wq_reg[DIST_W-1:0];
        d_neg     = (d_sat < prev_distance_reg);
        d_mag     = d_neg ? (prev_distance_reg - d_sat) : (d_sat - prev_distance_reg);
        prod_full = PROD_W'(d_mag) * SPEED_SCALE;
    end

    // Speed divider step over the gap.
    always_comb begin
        s_shift    = {srem_reg, prod_reg[PROD_W-1]};
        s_diff     = s_shift - {1'b0, gap_reg};
        s_ge       = (s_shift >= {1'b0, gap_reg});
        s_rem_next = s_ge ? s_diff[TIME_WIDTH-1:0] : s_shift[TIME_WIDTH-1:0];
    end

    // Signed speed with saturation to the output range.
    always_comb begin
        if (neg_reg) begin
            speed_sat = (prod_reg > SPEED_NEG_LIM) ? SPEED_MIN
                                                   : (~prod_reg[SPEED_W-1:0] + SPEED_W'(1));
        end else begin
            speed_sat = (prod_reg > SPEED_POS_LIM) ? SPEED_MAX : prod_reg[SPEED_W-1:0];
        end
    end

    // Working registers of the dividers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                if (q_pop) begin
                    flags_reg <= q_flags;
                    wq_reg    <= q_width;
                    gap_reg   <= q_gap;
                    wrem_reg  <= '0;
                    cnt_reg   <= CNT_W'(WIDTH_BITS - 1);
                end
            end
            B_DIVW: begin
                wrem_reg <= w_rem_next;
                wq_reg   <= {wq_reg[WIDTH_BITS-2:0], w_ge};
                cnt_reg  <= cnt_reg - CNT_W'(1);
            end
            B_MUL: begin
                prod_reg <= prod_full;
                neg_reg  <= d_neg;
                srem_reg <= '0;
                cnt_reg  <= CNT_W'(PROD_W - 1);
            end
            B_DIVS: begin
                srem_reg <= s_rem_next;
                prod_reg <= {prod_reg[PROD_W-2:0], s_ge};
                cnt_reg  <= cnt_reg - CNT_W'(1);
            end
            default: begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    // Result state and output register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= B_IDLE;
            distance_reg      <= '0;
            prev_distance_reg <= '0;
            speed_reg         <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_MUL) begin
                distance_reg      <= d_sat;
                prev_distance_reg <= d_sat;
            end
            if (state_reg == B_SPD) begin
                speed_reg <= speed_sat;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_data_reg <= OUT_TDATA_W'({flags_reg.done && flags_reg.speed_ok, speed_reg,
                                          distance_reg, flags_reg.done, flags_reg.trig});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    a_supd_needs_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[DIST_W+SPEED_W+2] && !m_tdata[1]))
        else $error("speed update reported without a measurement");
    a_pop_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (state_reg != B_IDLE))
        else $error("job popped but sequencer stayed idle");
    a_divw_to_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_DIVW && cnt_reg == '0) |=> (state_reg == B_MUL))
        else $error("distance division did not finish in step count");
    a_spd_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_SPD) |=> (state_reg == B_OUT))
        else $error("speed result not forwarded to output");
`endif

endmodule
`default_nettype wire

FILE: hdl/ultrasonic_range_speed_meter.sv
// Top level of the ultrasonic range and speed meter with its register port.
//
// Each input transaction is one microsecond tick and yields exactly one output
// transaction. A tick without a valid falling echo edge passes in the back end
// only through the idle and output states; a tick that ends an echo pulse also
// passes through the bit-serial distance division and the scaling step, and
// through the 31-step serial division of the scaled distance change by the
// gap when the speed is also updated. A four-entry queue lets the front end
// keep taking ticks while it has room and the back end divides, and the output
// register lets the back end start the next tick while a result waits to be taken.
`default_nettype none
module ultrasonic_range_speed_meter
    import urs_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF,
    parameter int WIDTH_BITS = WIDTH_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // Fields from bit 0: echo_level, start_request, zero padding.
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // Fields from bit 0: trig_level, measure_done, distance_cm[10:0],
    // speed_cm_s[21:0], speed_updated, zero padding.
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]       prdata,
    output logic                        pready
);

    localparam int JOB_W = FLAGS_W + WIDTH_BITS + TIME_WIDTH;

    logic [TICK_W-1:0]    trig_low_reg;
    logic [TICK_W-1:0]    trig_high_reg;
    logic [GAP_REG_W-1:0] min_gap_reg;
    logic [DIV_W-1:0]     width_div_reg;

    urs_reg_idx_t          reg_idx;
    logic                  cfg_write;
    logic                  in_accept;
    logic                  q_full, q_empty, q_pop;
    urs_job_flags_t        f_flags, b_flags;
    logic [WIDTH_BITS-1:0] f_width;
    logic [TIME_WIDTH-1:0] f_gap;
    logic [JOB_W-1:0]      q_head;

    // Register port decode.
    assign pready    = 1'b1;
    assign reg_idx   = urs_reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_low_reg  <= TRIG_LOW_RST;
            trig_high_reg <= TRIG_HIGH_RST;
            min_gap_reg   <= MIN_GAP_RST;
            width_div_reg <= WIDTH_DIV_RST;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_TRIG_LOW:  trig_low_reg  <= pwdata[TICK_W-1:0];
                REG_TRIG_HIGH: trig_high_reg <= pwdata[TICK_W-1:0];
                REG_MIN_GAP:   min_gap_reg   <= pwdata[GAP_REG_W-1:0];
                REG_WIDTH_DIV: width_div_reg <= pwdata[DIV_W-1:0];
                default: begin
                    trig_low_reg <= trig_low_reg;
                end
            endcase
        end
    end

    // Register readback.
    always_comb begin
        case (reg_idx)
            REG_TRIG_LOW:  prdata = APB_DATA_W'(trig_low_reg);
            REG_TRIG_HIGH: prdata = APB_DATA_W'(trig_high_reg);
            REG_MIN_GAP:   prdata = APB_DATA_W'(min_gap_reg);
            REG_WIDTH_DIV: prdata = APB_DATA_W'(width_div_reg);
            default:       prdata = '0;
        endcase
    end

    // A tick is taken whenever the queue has room for its job.
    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    urs_front #(
        .TIME_WIDTH (TIME_WIDTH),
        .WIDTH_BITS (WIDTH_BITS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_accept       (in_accept),
        .echo_level      (s_tdata[0]),
        .start_request   (s_tdata[1]),
        .trig_low_ticks  (trig_low_reg),
        .trig_high_ticks (trig_high_reg),
        .min_gap_ticks   (min_gap_reg),
        .job_flags       (f_flags),
        .job_width       (f_width),
        .job_gap         (f_gap)
    );

    urs_queue #(
        .DATA_W (JOB_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_accept),
        .push_data ({f_gap, f_width, f_flags}),
        .pop       (q_pop),
        .head_data (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign b_flags = urs_job_flags_t'(q_head[FLAGS_W-1:0]);

    urs_back #(
        .TIME_WIDTH (TIME_WIDTH),
        .WIDTH_BITS (WIDTH_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_flags       (b_flags),
        .q_width       (q_head[FLAGS_W +: WIDTH_BITS]),
        .q_gap         (q_head[FLAGS_W + WIDTH_BITS +: TIME_WIDTH]),
        .q_pop         (q_pop),
        .width_divisor (width_div_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

endmodule
`default_nettype wire
